@@ hw/rtl/tce_pkg.sv @@
package tce_pkg;

    localparam int TIME_W      = 48;
    localparam int AGE_W       = 39;
    localparam int MUL_LO_W    = 20;
    localparam int ACC_W       = 71;
    localparam int EXP_W       = 49;
    localparam int SLOT_MAX_W  = 10;
    localparam int DIV_X_W     = 45;
    localparam int RECIP_W     = 46;
    localparam int DIV_ACC_W   = 91;
    localparam int RECIP_SHIFT = 52;

    localparam logic [RECIP_W-1:0]   RECIP_125      = 46'd36028797018964;
    localparam logic [15:0]          INTERVAL_RST   = 16'd1000;
    localparam logic [31:0]          HITS_MAX       = 32'hFFFF_FFFF;

    localparam logic MODE_QUERY  = 1'b0;
    localparam logic MODE_INSERT = 1'b1;

    typedef struct packed {
        logic                mode;
        logic [31:0]         key;
        logic [31:0]         ttl_seconds;
        logic [TIME_W-1:0]   now_ms;
    } tce_item_t;

    typedef struct packed {
        logic        hit;
        logic [5:0]  slot;
        logic [31:0] ttl_left;
        logic        evicted;
    } tce_result_t;

    typedef struct packed {
        logic [31:0]       tag;
        logic [31:0]       ttl;
        logic [TIME_W-1:0] created;
        logic [31:0]       hits;
    } tce_rec_t;

    typedef struct packed {
        logic                  push;
        logic [SLOT_MAX_W-1:0] push_slot;
        logic                  pop_rd;
        logic                  pop_commit;
    } tce_fl_ctrl_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_Q_START,
        S_SW_RD,
        S_SW_EXP,
        S_SW_CHK,
        S_FD_RD,
        S_FD_CHK,
        S_Q_DIV,
        S_Q_UPD,
        S_EV_RD,
        S_EV_DIV,
        S_EV_WAIT,
        S_EV_MUL,
        S_EV_CMP,
        S_EV_REL,
        S_POP_RD,
        S_POP,
        S_WR,
        S_OUT
    } tce_state_t;

endpackage

@@ hw/rtl/tce_age_div.sv @@
module tce_age_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tce_pkg::TIME_W-1:0]  dividend,
    output logic                        done,
    output logic [tce_pkg::AGE_W-1:0]   quotient
);

    logic [tce_pkg::DIV_X_W-1:0]   x_reg, x_next;
    logic [tce_pkg::DIV_ACC_W-1:0] acc_reg, acc_next;
    logic [1:0]                    step_reg, step_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [31:0]                   mul_a;
    logic [31:0]                   mul_b;
    logic [63:0]                   product;
    logic [tce_pkg::DIV_ACC_W-1:0] addend;

    // age = ((ms >> 3) * RECIP_125) >> 52, built from four 32x32 partial products
    assign mul_a   = step_reg[1] ? 32'(x_reg[tce_pkg::DIV_X_W-1:32]) : x_reg[31:0];
    assign mul_b   = step_reg[0] ? 32'(tce_pkg::RECIP_125[tce_pkg::RECIP_W-1:32])
                                 : tce_pkg::RECIP_125[31:0];
    assign product = mul_a * mul_b;

    always_comb
    begin
        case (step_reg)
            2'd0:
                addend = tce_pkg::DIV_ACC_W'(product);
            2'd1, 2'd2:
                addend = tce_pkg::DIV_ACC_W'({product, 32'b0});
            default:
                addend = tce_pkg::DIV_ACC_W'({product, 64'b0});
        endcase
    end

    always_comb
    begin
        x_next    = x_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = dividend[tce_pkg::TIME_W-1:3];
            acc_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next  = acc_reg + addend;
            step_next = step_reg + 1'b1;
            if (step_reg == 2'd3)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        acc_reg <= acc_next;
    end

    assign done     = done_reg;
    assign quotient = acc_reg[tce_pkg::DIV_ACC_W-1:tce_pkg::RECIP_SHIFT];

endmodule

@@ hw/rtl/tce_entry_mem.sv @@
module tce_entry_mem #(
    parameter int ENTRIES = 64,
    parameter int SW      = 6
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [SW-1:0]     rd_addr,
    output tce_pkg::tce_rec_t rd_data,
    input  logic              wr_en,
    input  logic [SW-1:0]     wr_addr,
    input  tce_pkg::tce_rec_t wr_data
);

    tce_pkg::tce_rec_t mem [ENTRIES];
    tce_pkg::tce_rec_t rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_reg;

endmodule

@@ hw/rtl/tce_free_list.sv @@
module tce_free_list #(
    parameter int ENTRIES = 64,
    parameter int SW      = 6,
    parameter int CW      = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tce_pkg::tce_fl_ctrl_t ctrl,
    output logic [CW-1:0]         count,
    output logic [SW-1:0]         pop_slot
);

    localparam logic [CW:0]   NUM  = (CW+1)'(ENTRIES);
    localparam logic [SW-1:0] LAST = SW'(ENTRIES - 1);

    logic [SW-1:0]      mem [ENTRIES];
    logic [ENTRIES-1:0] wr_flag_reg, wr_flag_next;
    logic [SW-1:0]      head_reg, head_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [SW-1:0]      rd_q_reg;
    logic               rd_flag_reg;
    logic [SW-1:0]      rd_head_reg;
    logic [CW:0]        tail_sum;
    logic [SW-1:0]      tail;
    logic               push_ok;

    assign tail_sum = (CW+1)'(head_reg) + (CW+1)'(count_reg);
    assign tail     = (tail_sum >= NUM) ? SW'(tail_sum - NUM) : SW'(tail_sum);
    assign push_ok  = ctrl.push && ((CW+1)'(count_reg) < NUM);

    always_comb
    begin
        wr_flag_next = wr_flag_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        if (push_ok)
        begin
            wr_flag_next[tail] = 1'b1;
            count_next         = count_next + 1'b1;
        end
        if (ctrl.pop_commit)
        begin
            head_next  = (head_reg == LAST) ? '0 : head_reg + 1'b1;
            count_next = count_next - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_flag_reg <= '0;
            head_reg    <= '0;
            count_reg   <= CW'(ENTRIES);
        end
        else
        begin
            wr_flag_reg <= wr_flag_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[tail] <= SW'(ctrl.push_slot);
        end
        if (ctrl.pop_rd)
        begin
            rd_q_reg    <= mem[head_reg];
            rd_flag_reg <= wr_flag_reg[head_reg];
            rd_head_reg <= head_reg;
        end
    end

    assign count    = count_reg;
    assign pop_slot = rd_flag_reg ? rd_q_reg : rd_head_reg;

endmodule

@@ hw/rtl/ttl_cache_weighted_evict_core.sv @@
// TTL cache tag store with frequency/age eviction. Items are taken one at a
// time: item_stall stays high from acceptance until the result is loaded into
// the output register. All slot scans share one read port of the entry memory.
// The eviction scan and a query hit share one divide-by-1000 unit that
// multiplies by a reciprocal in four 32x32 steps. A query first runs an expiry
// sweep over the live slots when one is due, then reads each live slot and
// compares its tag; on a hit it divides the entry's age and writes back its
// hit count. An insert with a free slot pops it and scans for the key; when
// the pool is full an eviction scan runs first, which reads each live slot,
// divides its age and, from the second live slot on, runs four multiply steps
// on one 32x20 multiplier and compares. No clearing pass is needed after reset.
module ttl_cache_weighted_evict_core #(
    parameter int ENTRIES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wen,
    input  logic [15:0]          cfg_wdata,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  tce_pkg::tce_item_t   item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output tce_pkg::tce_result_t result
);

    localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [SW-1:0] LAST = SW'(ENTRIES - 1);

    tce_pkg::tce_state_t   state_reg, state_next;
    tce_pkg::tce_item_t    item_reg, item_next;
    logic [tce_pkg::TIME_W-1:0] last_sweep_reg, last_sweep_next;
    logic [15:0]           interval_reg;
    logic [ENTRIES-1:0]    valid_reg, valid_next;
    logic [SW-1:0]         idx_reg, idx_next;
    logic [SW-1:0]         slot_reg, slot_next;
    logic [SW-1:0]         best_idx_reg, best_idx_next;
    logic                  best_found_reg, best_found_next;
    logic [31:0]           best_hits_reg, best_hits_next;
    logic [tce_pkg::AGE_W-1:0] best_age1_reg, best_age1_next;
    logic [31:0]           cur_hits_reg, cur_hits_next;
    logic [tce_pkg::AGE_W-1:0] cur_age1_reg, cur_age1_next;
    logic [tce_pkg::ACC_W-1:0] acc_a_reg, acc_a_next;
    logic [tce_pkg::ACC_W-1:0] acc_b_reg, acc_b_next;
    logic [1:0]            mstep_reg, mstep_next;
    logic [tce_pkg::EXP_W-1:0] exp_reg, exp_next;
    logic                  evicted_reg, evicted_next;
    tce_pkg::tce_result_t  pend_reg, pend_next;
    tce_pkg::tce_result_t  result_reg, result_next;
    logic                  result_valid_reg, result_valid_next;

    logic                  mem_rd_en;
    tce_pkg::tce_rec_t     rec;
    logic                  mem_wr_en;
    tce_pkg::tce_rec_t     mem_wr_data;
    tce_pkg::tce_fl_ctrl_t fl_ctrl;
    logic [CW-1:0]         fl_count;
    logic [SW-1:0]         fl_pop_slot;
    logic                  div_start;
    logic [tce_pkg::TIME_W-1:0] div_dividend;
    logic                  div_done;
    logic [tce_pkg::AGE_W-1:0] div_quotient;

    logic                  cur_valid;
    logic                  idx_last;
    logic [SW-1:0]         idx_adv;
    logic                  sweep_go;
    logic [41:0]           ttl_x1000;
    logic                  expired;
    logic                  tag_hit;
    logic [tce_pkg::TIME_W-1:0] rec_age_ms;
    logic [tce_pkg::AGE_W-1:0]  age1;
    logic [31:0]           mul_a;
    logic [tce_pkg::AGE_W-1:0]  mul_src;
    logic [tce_pkg::MUL_LO_W-1:0] mul_b;
    logic [51:0]           product;
    logic                  lighter;
    logic                  out_load;
    logic [31:0]           rem_ttl;
    logic                  rel_en;
    logic [SW-1:0]         rel_slot;
    logic                  set_en;

    tce_entry_mem #(
        .ENTRIES (ENTRIES),
        .SW      (SW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (idx_reg),
        .rd_data (rec),
        .wr_en   (mem_wr_en),
        .wr_addr (slot_reg),
        .wr_data (mem_wr_data)
    );

    tce_free_list #(
        .ENTRIES (ENTRIES),
        .SW      (SW),
        .CW      (CW)
    ) u_free (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (fl_ctrl),
        .count    (fl_count),
        .pop_slot (fl_pop_slot)
    );

    tce_age_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign cur_valid  = valid_reg[idx_reg];
    assign idx_last   = (idx_reg == LAST);
    assign idx_adv    = idx_last ? '0 : idx_reg + 1'b1;
    assign sweep_go   = (item_reg.now_ms >= last_sweep_reg) &&
                        ((item_reg.now_ms - last_sweep_reg) >=
                         tce_pkg::TIME_W'(interval_reg));
    assign ttl_x1000  = {rec.ttl, 10'b0} - {6'b0, rec.ttl, 4'b0} - {7'b0, rec.ttl, 3'b0};
    assign expired    = ({1'b0, item_reg.now_ms} >= exp_reg);
    assign tag_hit    = (rec.tag == item_reg.key);
    assign rec_age_ms = (item_reg.now_ms >= rec.created) ?
                        item_reg.now_ms - rec.created : '0;
    assign age1       = div_quotient + 1'b1;
    assign mul_a      = mstep_reg[1] ? best_hits_reg : cur_hits_reg;
    assign mul_src    = mstep_reg[1] ? cur_age1_reg : best_age1_reg;
    assign mul_b      = mstep_reg[0] ? {1'b0, mul_src[tce_pkg::AGE_W-1:tce_pkg::MUL_LO_W]}
                                     : mul_src[tce_pkg::MUL_LO_W-1:0];
    assign product    = mul_a * mul_b;
    assign lighter    = (acc_a_reg < acc_b_reg);
    assign out_load   = !result_valid_reg || !result_stall;
    assign rem_ttl    = (div_quotient < {7'b0, rec.ttl}) ?
                        rec.ttl - div_quotient[31:0] : 32'd1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tce_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.mode == tce_pkg::MODE_INSERT)
                    begin
                        state_next = (fl_count == '0) ? tce_pkg::S_EV_RD : tce_pkg::S_POP_RD;
                    end
                    else
                    begin
                        state_next = tce_pkg::S_Q_START;
                    end
                end
            end
            tce_pkg::S_Q_START:
                state_next = sweep_go ? tce_pkg::S_SW_RD : tce_pkg::S_FD_RD;
            tce_pkg::S_SW_RD:
            begin
                if (cur_valid)
                    state_next = tce_pkg::S_SW_EXP;
                else if (idx_last)
                    state_next = tce_pkg::S_FD_RD;
            end
            tce_pkg::S_SW_EXP:
                state_next = tce_pkg::S_SW_CHK;
            tce_pkg::S_SW_CHK:
                state_next = idx_last ? tce_pkg::S_FD_RD : tce_pkg::S_SW_RD;
            tce_pkg::S_FD_RD:
            begin
                if (cur_valid)
                    state_next = tce_pkg::S_FD_CHK;
                else if (idx_last)
                    state_next = (item_reg.mode == tce_pkg::MODE_QUERY) ?
                                 tce_pkg::S_OUT : tce_pkg::S_WR;
            end
            tce_pkg::S_FD_CHK:
            begin
                if (tag_hit)
                    state_next = (item_reg.mode == tce_pkg::MODE_QUERY) ?
                                 tce_pkg::S_Q_DIV : tce_pkg::S_WR;
                else if (idx_last)
                    state_next = (item_reg.mode == tce_pkg::MODE_QUERY) ?
                                 tce_pkg::S_OUT : tce_pkg::S_WR;
                else
                    state_next = tce_pkg::S_FD_RD;
            end
            tce_pkg::S_Q_DIV:
            begin
                if (div_done)
                    state_next = tce_pkg::S_Q_UPD;
            end
            tce_pkg::S_Q_UPD:
                state_next = tce_pkg::S_OUT;
            tce_pkg::S_EV_RD:
            begin
                if (cur_valid)
                    state_next = tce_pkg::S_EV_DIV;
                else if (idx_last)
                    state_next = tce_pkg::S_EV_REL;
            end
            tce_pkg::S_EV_DIV:
                state_next = tce_pkg::S_EV_WAIT;
            tce_pkg::S_EV_WAIT:
            begin
                if (div_done)
                begin
                    if (best_found_reg)
                        state_next = tce_pkg::S_EV_MUL;
                    else
                        state_next = idx_last ? tce_pkg::S_EV_REL : tce_pkg::S_EV_RD;
                end
            end
            tce_pkg::S_EV_MUL:
            begin
                if (mstep_reg == 2'd3)
                    state_next = tce_pkg::S_EV_CMP;
            end
            tce_pkg::S_EV_CMP:
                state_next = idx_last ? tce_pkg::S_EV_REL : tce_pkg::S_EV_RD;
            tce_pkg::S_EV_REL:
                state_next = tce_pkg::S_POP_RD;
            tce_pkg::S_POP_RD:
                state_next = (fl_count != '0) ? tce_pkg::S_POP : tce_pkg::S_OUT;
            tce_pkg::S_POP:
                state_next = tce_pkg::S_FD_RD;
            tce_pkg::S_WR:
                state_next = tce_pkg::S_OUT;
            tce_pkg::S_OUT:
            begin
                if (out_load)
                    state_next = tce_pkg::S_IDLE;
            end
            default:
                state_next = tce_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        item_next       = item_reg;
        last_sweep_next = last_sweep_reg;
        idx_next        = idx_reg;
        slot_next       = slot_reg;
        best_idx_next   = best_idx_reg;
        best_found_next = best_found_reg;
        best_hits_next  = best_hits_reg;
        best_age1_next  = best_age1_reg;
        cur_hits_next   = cur_hits_reg;
        cur_age1_next   = cur_age1_reg;
        acc_a_next      = acc_a_reg;
        acc_b_next      = acc_b_reg;
        mstep_next      = mstep_reg;
        exp_next        = exp_reg;
        evicted_next    = evicted_reg;
        pend_next       = pend_reg;
        mem_rd_en       = 1'b0;
        mem_wr_en       = 1'b0;
        mem_wr_data     = rec;
        div_start       = 1'b0;
        div_dividend    = rec_age_ms;
        rel_en          = 1'b0;
        rel_slot        = idx_reg;
        set_en          = 1'b0;
        fl_ctrl         = '0;
        case (state_reg)
            tce_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next       = item;
                    evicted_next    = 1'b0;
                    idx_next        = '0;
                    best_found_next = 1'b0;
                end
            end
            tce_pkg::S_Q_START:
            begin
                if (sweep_go)
                    last_sweep_next = item_reg.now_ms;
            end
            tce_pkg::S_SW_RD, tce_pkg::S_EV_RD:
            begin
                if (cur_valid)
                    mem_rd_en = 1'b1;
                else
                    idx_next = idx_adv;
            end
            tce_pkg::S_SW_EXP:
                exp_next = {1'b0, rec.created} + {7'b0, ttl_x1000};
            tce_pkg::S_SW_CHK:
            begin
                rel_en   = expired;
                idx_next = idx_adv;
            end
            tce_pkg::S_FD_RD:
            begin
                if (cur_valid)
                    mem_rd_en = 1'b1;
                else
                begin
                    idx_next = idx_adv;
                    if (idx_last)
                        pend_next = '0;
                end
            end
            tce_pkg::S_FD_CHK:
            begin
                if (tag_hit)
                begin
                    if (item_reg.mode == tce_pkg::MODE_QUERY)
                    begin
                        div_start = 1'b1;
                        slot_next = idx_reg;
                    end
                    else
                    begin
                        rel_en = 1'b1;
                    end
                end
                else
                begin
                    idx_next = idx_adv;
                    if (idx_last)
                        pend_next = '0;
                end
            end
            tce_pkg::S_Q_UPD:
            begin
                mem_wr_en        = 1'b1;
                mem_wr_data.hits = (rec.hits == tce_pkg::HITS_MAX) ? rec.hits
                                                                   : rec.hits + 1'b1;
                pend_next.hit           = 1'b1;
                pend_next.slot          = 6'(slot_reg);
                pend_next.ttl_left      = rem_ttl;
                pend_next.evicted       = 1'b0;
            end
            tce_pkg::S_EV_DIV:
            begin
                div_start     = 1'b1;
                cur_hits_next = rec.hits;
            end
            tce_pkg::S_EV_WAIT:
            begin
                if (div_done)
                begin
                    cur_age1_next = age1;
                    mstep_next    = '0;
                    if (!best_found_reg)
                    begin
                        best_found_next = 1'b1;
                        best_idx_next   = idx_reg;
                        best_hits_next  = cur_hits_reg;
                        best_age1_next  = age1;
                        idx_next        = idx_adv;
                    end
                end
            end
            tce_pkg::S_EV_MUL:
            begin
                mstep_next = mstep_reg + 1'b1;
                case (mstep_reg)
                    2'd0: acc_a_next = tce_pkg::ACC_W'(product);
                    2'd1: acc_a_next = acc_a_reg + {product[50:0], 20'b0};
                    2'd2: acc_b_next = tce_pkg::ACC_W'(product);
                    default: acc_b_next = acc_b_reg + {product[50:0], 20'b0};
                endcase
            end
            tce_pkg::S_EV_CMP:
            begin
                if (lighter)
                begin
                    best_idx_next  = idx_reg;
                    best_hits_next = cur_hits_reg;
                    best_age1_next = cur_age1_reg;
                end
                idx_next = idx_adv;
            end
            tce_pkg::S_EV_REL:
            begin
                if (best_found_reg)
                begin
                    rel_en       = 1'b1;
                    rel_slot     = best_idx_reg;
                    evicted_next = 1'b1;
                end
            end
            tce_pkg::S_POP_RD:
            begin
                if (fl_count != '0)
                    fl_ctrl.pop_rd = 1'b1;
                else
                begin
                    pend_next         = '0;
                    pend_next.evicted = evicted_reg;
                end
            end
            tce_pkg::S_POP:
            begin
                slot_next          = fl_pop_slot;
                fl_ctrl.pop_commit = 1'b1;
                idx_next           = '0;
            end
            tce_pkg::S_WR:
            begin
                mem_wr_en           = 1'b1;
                mem_wr_data.tag     = item_reg.key;
                mem_wr_data.ttl     = item_reg.ttl_seconds;
                mem_wr_data.created = item_reg.now_ms;
                mem_wr_data.hits    = '0;
                set_en              = 1'b1;
                pend_next.hit           = 1'b1;
                pend_next.slot          = 6'(slot_reg);
                pend_next.ttl_left      = (item_reg.ttl_seconds != '0) ?
                                          item_reg.ttl_seconds : 32'd1;
                pend_next.evicted       = evicted_reg;
            end
            default:
            begin
            end
        endcase
        fl_ctrl.push      = rel_en;
        fl_ctrl.push_slot = tce_pkg::SLOT_MAX_W'(rel_slot);
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (rel_en)
            valid_next[rel_slot] = 1'b0;
        if (set_en)
            valid_next[slot_reg] = 1'b1;
    end

    always_comb
    begin
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;
        if ((state_reg == tce_pkg::S_OUT) && out_load)
        begin
            result_next       = pend_reg;
            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tce_pkg::S_IDLE;
            last_sweep_reg   <= '0;
            interval_reg     <= tce_pkg::INTERVAL_RST;
            valid_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            last_sweep_reg   <= last_sweep_next;
            valid_reg        <= valid_next;
            result_valid_reg <= result_valid_next;
            if (cfg_wen)
                interval_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        idx_reg        <= idx_next;
        slot_reg       <= slot_next;
        best_idx_reg   <= best_idx_next;
        best_found_reg <= best_found_next;
        best_hits_reg  <= best_hits_next;
        best_age1_reg  <= best_age1_next;
        cur_hits_reg   <= cur_hits_next;
        cur_age1_reg   <= cur_age1_next;
        acc_a_reg      <= acc_a_next;
        acc_b_reg      <= acc_b_next;
        mstep_reg      <= mstep_next;
        exp_reg        <= exp_next;
        evicted_reg    <= evicted_next;
        pend_reg       <= pend_next;
        result_reg     <= result_next;
    end

    assign item_stall   = (state_reg != tce_pkg::S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    a_slots_accounted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tce_pkg::S_IDLE) |->
            ((CW+1)'(fl_count) + (CW+1)'($countones(valid_reg)) == (CW+1)'(ENTRIES)))
        else $error("free count and live slots disagree");

    a_write_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tce_pkg::S_WR) |-> !valid_reg[slot_reg])
        else $error("insert overwrites a live slot");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == tce_pkg::S_Q_DIV || state_reg == tce_pkg::S_EV_WAIT))
        else $error("age divide finished outside a wait state");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == tce_pkg::S_OUT))
        else $error("result loaded outside output state");
`endif

endmodule
